[src/sliding_window_morph_filter_core_assert.svh]
// assertion macros used by the morphology filter checker
`ifndef SLIDING_WINDOW_MORPH_FILTER_CORE_ASSERT_SVH
`define SLIDING_WINDOW_MORPH_FILTER_CORE_ASSERT_SVH

// same-cycle implication, checking suspended during reset
`define SWMF_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("swmf check failed");

// next-cycle implication, checking suspended during reset
`define SWMF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("swmf check failed");

`endif

[src/swmf_pkg.sv]
// shared constants and types of the sliding window morphology filter
package swmf_pkg;

  // configuration port
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 7;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_LENGTH = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MODE          = 1'b1;

  // register widths
  localparam int WL_BITS    = 7;
  localparam int COUNT_BITS = 7;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = 7'd127;
  localparam logic [WL_BITS-1:0]    WL_RESET  = 7'd1;

  // filter operation
  typedef enum logic [1:0] {
    MODE_DILATE   = 2'd0,
    MODE_ERODE    = 2'd1,
    MODE_GRADIENT = 2'd2,
    MODE_AVERAGE  = 2'd3
  } mode_t;

endpackage

[src/swmf_if.sv]
// valid/ready stream interfaces for samples and filtered results
interface swmf_sample_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

interface swmf_result_if #(parameter int SAMPLE_BITS = 16);
  logic                        valid;
  logic                        ready;
  logic signed [SAMPLE_BITS:0] filtered_value;
  logic                        end_of_waveform;

  modport source (output valid, output filtered_value, output end_of_waveform, input ready);
  modport sink   (input valid, input filtered_value, input end_of_waveform, output ready);
endinterface

[src/swmf_cell.sv]
// one cell of the running max/min chain
module swmf_cell #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [SAMPLE_BITS-1:0] x,
  input  logic signed [SAMPLE_BITS-1:0] prev_max,
  input  logic signed [SAMPLE_BITS-1:0] prev_min,
  output logic signed [SAMPLE_BITS-1:0] run_max,
  output logic signed [SAMPLE_BITS-1:0] run_min
);

  // extremes of the newest samples, one more than the neighbor covers
  always_ff @(posedge clk) begin
    if (en) begin
      run_max <= (x > prev_max) ? x : prev_max;
      run_min <= (x < prev_min) ? x : prev_min;
    end
  end

endmodule

[src/swmf_emit.sv]
// result register: combines max/min by mode and repeats tail outputs
module swmf_emit #(
  parameter int SAMPLE_BITS = 16,
  parameter int REM_BITS    = 5
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  logic signed [SAMPLE_BITS-1:0] win_max,
  input  logic signed [SAMPLE_BITS-1:0] win_min,
  input  swmf_pkg::mode_t               mode,
  input  logic [REM_BITS-1:0]           rem_in,
  input  logic                          last_in,
  output logic                          free,
  swmf_result_if.source                 result_ch
);

  logic                        valid;
  logic signed [SAMPLE_BITS:0] value;
  logic [REM_BITS-1:0]         rem;
  logic                        eow_flag;

  logic signed [SAMPLE_BITS:0] max_ext;
  logic signed [SAMPLE_BITS:0] min_ext;
  logic signed [SAMPLE_BITS:0] sum_adj;
  logic signed [SAMPLE_BITS:0] value_next;
  logic                        done;

  // mode combine, average rounds toward zero
  always_comb begin
    max_ext = {win_max[SAMPLE_BITS-1], win_max};
    min_ext = {win_min[SAMPLE_BITS-1], win_min};
    sum_adj = max_ext + min_ext;
    sum_adj = sum_adj + {{SAMPLE_BITS{1'b0}}, sum_adj[SAMPLE_BITS]};
    unique case (mode)
      swmf_pkg::MODE_DILATE:   value_next = max_ext;
      swmf_pkg::MODE_ERODE:    value_next = min_ext;
      swmf_pkg::MODE_GRADIENT: value_next = max_ext - min_ext;
      swmf_pkg::MODE_AVERAGE:  value_next = sum_adj >>> 1;
      default:                 value_next = max_ext;
    endcase
  end

  assign done = valid && result_ch.ready && (rem == '0);
  assign free = !valid || done;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (done) begin
      valid <= 1'b0;
    end
  end

  // payload and repeat count
  always_ff @(posedge clk) begin
    if (load) begin
      value    <= value_next;
      rem      <= rem_in;
      eow_flag <= last_in;
    end else if (valid && result_ch.ready && rem != '0) begin
      rem <= rem - 1'b1;
    end
  end

  assign result_ch.valid           = valid;
  assign result_ch.filtered_value  = value;
  assign result_ch.end_of_waveform = eow_flag && (rem == '0);

endmodule

[src/sliding_window_morph_filter_core.sv]
// Path: a sample transaction is registered in stage one and the cell chain, then
//   the result register (swmf_emit) loads the result it releases and offers it.
// Throughput: one sample per cycle; the tail outputs of a waveform (up to
//   MAX_HALF) drain while the first h samples of the next one release nothing,
//   so input only waits behind a result that the receiver holds.
// Reset: synchronous rst clears the pipeline, the sample count, window_length
//   to 1 and mode to dilation; the cell chain needs no clearing.
module sliding_window_morph_filter_core #(
  parameter int MAX_HALF    = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [swmf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [swmf_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  swmf_sample_if.sink                         sample_ch,
  swmf_result_if.source                       result_ch
);

  localparam int DEPTH = 2 * MAX_HALF + 1;
  localparam int SW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int HB    = (MAX_HALF > 0) ? $clog2(MAX_HALF + 1) : 1;
  localparam int CB    = swmf_pkg::COUNT_BITS;

  // configuration registers
  logic [swmf_pkg::WL_BITS-1:0] window_length;
  swmf_pkg::mode_t              mode;

  // stream state and first stage
  logic [CB-1:0] samples_seen;
  logic          s1_valid;
  logic          s1_emit;
  logic          s1_last;
  logic [SW-1:0] s1_sel;
  logic [HB-1:0] s1_rem;

  logic          accept;
  logic          s1_go;
  logic          emit_free;
  logic          emit_load;
  logic [5:0]    half_raw;
  logic [5:0]    half_clip;
  logic [CB-1:0] half_ext;
  logic [CB-1:0] two_h;
  logic [CB-1:0] sel_full;
  logic [5:0]    rem_full;
  logic          full_win;

  logic signed [SAMPLE_BITS-1:0] cell_max [DEPTH];
  logic signed [SAMPLE_BITS-1:0] cell_min [DEPTH];

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= swmf_pkg::WL_RESET;
      mode          <= swmf_pkg::MODE_DILATE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        swmf_pkg::CFG_WINDOW_LENGTH: window_length <= cfg_data;
        swmf_pkg::CFG_MODE:          mode <= swmf_pkg::mode_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  // half width, window select and tail length for the incoming sample
  always_comb begin
    half_raw  = window_length[6:1];
    half_clip = (half_raw > 6'(MAX_HALF)) ? 6'(MAX_HALF) : half_raw;
    half_ext  = {1'b0, half_clip};
    two_h     = {half_clip, 1'b0};
    full_win  = (samples_seen >= half_ext);
    sel_full  = (samples_seen < two_h) ? samples_seen : two_h;
    rem_full  = full_win ? half_clip : samples_seen[5:0];
  end

  // handshake
  assign s1_go           = !s1_emit || emit_free;
  assign sample_ch.ready = !s1_valid || s1_go;
  assign accept          = sample_ch.valid && sample_ch.ready;
  assign emit_load       = s1_valid && s1_emit && emit_free;

  // stage one control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      samples_seen <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      if (accept) begin
        if (sample_ch.last) begin
          samples_seen <= '0;
        end else if (samples_seen != swmf_pkg::COUNT_MAX) begin
          samples_seen <= samples_seen + 1'b1;
        end
      end
    end
  end

  // stage one payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_emit <= full_win || sample_ch.last;
      s1_last <= sample_ch.last;
      s1_sel  <= sel_full[SW-1:0];
      s1_rem  <= sample_ch.last ? rem_full[HB-1:0] : '0;
    end
  end

  // chain of running max/min cells, cell j covers the newest j+1 samples
  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    if (j == 0) begin : g_head
      swmf_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
        .clk      (clk),
        .en       (accept),
        .x        (sample_ch.sample),
        .prev_max (sample_ch.sample),
        .prev_min (sample_ch.sample),
        .run_max  (cell_max[j]),
        .run_min  (cell_min[j])
      );
    end else begin : g_body
      swmf_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
        .clk      (clk),
        .en       (accept),
        .x        (sample_ch.sample),
        .prev_max (cell_max[j-1]),
        .prev_min (cell_min[j-1]),
        .run_max  (cell_max[j]),
        .run_min  (cell_min[j])
      );
    end
  end

  // result register with tail repeats
  swmf_emit #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .REM_BITS    (HB)
  ) u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (emit_load),
    .win_max   (cell_max[s1_sel]),
    .win_min   (cell_min[s1_sel]),
    .mode      (mode),
    .rem_in    (s1_rem),
    .last_in   (s1_last),
    .free      (emit_free),
    .result_ch (result_ch)
  );

endmodule

[src/swmf_checker.sv]
// port-level checks of the morphology filter and their binding
`include "sliding_window_morph_filter_core_assert.svh"

module swmf_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic signed [SAMPLE_BITS:0] filtered_value,
  input logic                        end_of_waveform
);

  // a stalled result holds
  `SWMF_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
    out_valid && $stable(filtered_value) && $stable(end_of_waveform))

  // nothing offered right after reset
  `SWMF_ASSERT_IMPLY(a_reset_idle, clk, rst, $past(rst), !out_valid)

  // input only backs up behind a waiting result
  `SWMF_ASSERT_IMPLY(a_stall_cause, clk, rst, !in_ready, out_valid)

  // a waiting sample transaction stays offered
  `SWMF_ASSERT_NEXT(a_in_hold, clk, rst, in_valid && !in_ready, in_valid)

endmodule

bind sliding_window_morph_filter_core swmf_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_swmf_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (sample_ch.valid),
  .in_ready        (sample_ch.ready),
  .out_valid       (result_ch.valid),
  .out_ready       (result_ch.ready),
  .filtered_value  (result_ch.filtered_value),
  .end_of_waveform (result_ch.end_of_waveform)
);

[sim/sliding_window_morph_filter_core_test.sv]
// self-checking testbench of the sliding window morphology filter core
module sliding_window_morph_filter_core_test;

  localparam int PERIOD       = 10;
  localparam int MAX_HALF     = 16;
  localparam int SAMPLE_BITS  = 16;
  localparam int HIST_DEPTH   = 2 * MAX_HALF + 1;
  localparam int SETTLE_CYCLES = 8;
  localparam int TIMEOUT      = 20_000_000;
  localparam int DIRECTED_ROWS = 35;

  typedef struct packed {
    logic signed [SAMPLE_BITS:0] value;
    logic                        eow;
  } filtered_t;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t                               kind;
    logic [swmf_pkg::CFG_INDEX_BITS-1:0]     reg_index;
    logic [swmf_pkg::CFG_DATA_BITS-1:0]      reg_value;
    logic signed [SAMPLE_BITS-1:0]           x;
    logic                                    is_last;
    bit                                      typed;
    logic signed [SAMPLE_BITS:0]             typed_value;
    logic                                    typed_eow;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [swmf_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  logic [swmf_pkg::CFG_DATA_BITS-1:0]  cfg_data;

  swmf_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) sample_ch ();
  swmf_result_if #(.SAMPLE_BITS(SAMPLE_BITS)) result_ch ();

  sliding_window_morph_filter_core #(
    .MAX_HALF   (MAX_HALF),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .sample_ch(sample_ch),
    .result_ch(result_ch)
  );

  // filter state as the block should hold it
  logic signed [SAMPLE_BITS-1:0]       window_hist [HIST_DEPTH];
  logic [swmf_pkg::COUNT_BITS-1:0]     wave_count;
  logic [swmf_pkg::WL_BITS-1:0]        cur_wl;
  swmf_pkg::mode_t                     cur_mode;

  filtered_t step_outputs [$];
  filtered_t pending_filtered [$];
  filtered_t head_filtered;

  int fail_count;
  int send_gap_pct;
  int recv_stall_pct;

  // directed stimulus: extremes, every mode, clipped start, short stream,
  // tails, zero half width, clamped window and a change inside a waveform
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{ROW_SAMPLE, swmf_pkg::CFG_MODE, 7'd0, 16'sh7fff, 1'b0, 1'b1, 17'sd32767, 1'b0},
    '{ROW_SAMPLE, swmf_pkg::CFG_MODE, 7'd0, 16'sh8000, 1'b1, 1'b1, -17'sd32768, 1'b1},
    '{ROW_WRITE, swmf_pkg::CFG_MODE, 7'(swmf_pkg::MODE_ERODE), 16'sd0, 1'b0, 1'b0, 17'sd0, 1'b0},
    '{ROW_SAMPLE, swmf_pkg::CFG_MODE, 7'd0, 16'sh5a5a, 1'b0, 1'b1, 17'sh05a5a, 1'b0},
    '{ROW_WRITE, swmf_pkg::CFG_MODE, 7'(swmf_pkg::MODE_GRADIENT), 16'sd0, 1'b0, 1'b0, 17'sd0,
      1'b0},
    '{ROW_WRITE, swmf_pkg::CFG_WINDOW_LENGTH, 7'd0, 16'sd0, 1'b0, 1'b0, 17'sd0, 1'b0},
    '{ROW_SAMPLE, swmf_pkg::CFG_MODE, 7'd0, 16'sh8000, 1'b1, 1'b1, 17'sd0, 1'b1},
    '{ROW_WRITE, swmf_pkg::CFG_WINDOW_LENGTH, 7'd5, 16'sd0, 1'b0, 1'b0, 17'sd0, 1'b0},
    '{ROW_SAMPLE, swmf_pkg::CFG_MODE, 7'd0, 16'sh8000, 1'b0, 1'b0, 17'sd0, 1'b0},
    '{ROW_SAMPLE, swmf_pkg::CFG_MODE, 7'd0, 16'sh7fff, 1'b0, 1'b0, 17'sd0, 1'b0},
    '{ROW_SAMPLE, swmf_pkg::CFG_MODE, 7'd0, 16'sd0, 1'b0, 1'b0, 17'sd0, 1'b0},
    '{ROW_SAMPLE, swmf_pkg::CFG_MODE, 7'd0, 16'sh1234, 1'b0, 1'b0, 17'sd0, 1'b0},
    '{ROW_SAMPLE, swmf_pkg::CFG_MODE, 7'd0, 16'sh8001, 1'b1, 1'b0, 17'sd0, 1'b0},
    '{ROW_WRITE, swmf_pkg::CFG_MODE, 7'(swmf_pkg::MODE_AVERAGE), 16'sd0, 1'b0, 1'b0, 17'sd0,
      1'b0},
    '{ROW_WRITE, swmf_pkg::CFG_WINDOW_LENGTH, 7'd3, 16'sd0, 1'b0, 1'b0, 17'sd0, 1'b0},
    '{ROW_SAMPLE, swmf_pkg::CFG_MODE, 7'd0, -16'sd1, 1'b0, 1'b0, 17'sd0, 1'b0},
    '{ROW_SAMPLE, swmf_pkg::CFG_MODE, 7'd0, -16'sd4, 1'b0, 1'b0, 17'sd0, 1'b0},
    '{ROW_SAMPLE, swmf_pkg::CFG_MODE, 7'd0, 16'sh7fff, 1'b0, 1'b0, 17'sd0, 1'b0},
    '{ROW_SAMPLE, swmf_pkg::CFG_MODE, 7'd0, 16'sh8000, 1'b1, 1'b0, 17'sd0, 1'b0},
    '{ROW_WRITE, swmf_pkg::CFG_WINDOW_LENGTH, 7'd127, 16'sd0, 1'b0, 1'b0, 17'sd0, 1'b0},
    '{ROW_WRITE, swmf_pkg::CFG_MODE, 7'(swmf_pkg::MODE_ERODE), 16'sd0, 1'b0, 1'b0, 17'sd0, 1'b0},
    '{ROW_SAMPLE, swmf_pkg::CFG_MODE, 7'd0, 16'sd100, 1'b0, 1'b0, 17'sd0, 1'b0},
    '{ROW_SAMPLE, swmf_pkg::CFG_MODE, 7'd0, -16'sd5, 1'b0, 1'b0, 17'sd0, 1'b0},
    '{ROW_SAMPLE, swmf_pkg::CFG_MODE, 7'd0, 16'sh7ffe, 1'b1, 1'b0, 17'sd0, 1'b0},
    '{ROW_WRITE, swmf_pkg::CFG_WINDOW_LENGTH, 7'd9, 16'sd0, 1'b0, 1'b0, 17'sd0, 1'b0},
    '{ROW_WRITE, swmf_pkg::CFG_MODE, 7'(swmf_pkg::MODE_DILATE), 16'sd0, 1'b0, 1'b0, 17'sd0, 1'b0},
    '{ROW_SAMPLE, swmf_pkg::CFG_MODE, 7'd0, 16'sd7, 1'b1, 1'b1, 17'sd7, 1'b1},
    '{ROW_WRITE, swmf_pkg::CFG_WINDOW_LENGTH, 7'd3, 16'sd0, 1'b0, 1'b0, 17'sd0, 1'b0},
    '{ROW_SAMPLE, swmf_pkg::CFG_MODE, 7'd0, 16'sd10, 1'b0, 1'b0, 17'sd0, 1'b0},
    '{ROW_SAMPLE, swmf_pkg::CFG_MODE, 7'd0, -16'sd20, 1'b0, 1'b0, 17'sd0, 1'b0},
    '{ROW_SAMPLE, swmf_pkg::CFG_MODE, 7'd0, 16'sd30, 1'b0, 1'b0, 17'sd0, 1'b0},
    '{ROW_WRITE, swmf_pkg::CFG_WINDOW_LENGTH, 7'd7, 16'sd0, 1'b0, 1'b0, 17'sd0, 1'b0},
    '{ROW_SAMPLE, swmf_pkg::CFG_MODE, 7'd0, 16'sd5, 1'b0, 1'b0, 17'sd0, 1'b0},
    '{ROW_SAMPLE, swmf_pkg::CFG_MODE, 7'd0, -16'sd1, 1'b0, 1'b0, 17'sd0, 1'b0},
    '{ROW_SAMPLE, swmf_pkg::CFG_MODE, 7'd0, 16'sd2, 1'b1, 1'b0, 17'sd0, 1'b0}
  };

  always #(PERIOD / 2) clk = ~clk;

  // shift one sample into the window and work out the outputs it releases
  function automatic void slide_window(input logic signed [SAMPLE_BITS-1:0] x,
                                       input logic is_last);
    int half, seen, span, hi, lo, level, j;
    logic signed [SAMPLE_BITS:0] value;
    half = cur_wl / 2;
    if (half > MAX_HALF) half = MAX_HALF;
    seen = wave_count;
    for (j = HIST_DEPTH - 1; j > 0; j--) window_hist[j] = window_hist[j-1];
    window_hist[0] = x;
    span = (seen + 1 < 2 * half + 1) ? seen + 1 : 2 * half + 1;
    if (wave_count != swmf_pkg::COUNT_MAX) wave_count = wave_count + 1'b1;
    step_outputs.delete();
    if (seen >= half || is_last) begin
      hi = window_hist[0];
      lo = window_hist[0];
      for (j = 1; j < span; j++) begin
        if (window_hist[j] > hi) hi = window_hist[j];
        if (window_hist[j] < lo) lo = window_hist[j];
      end
      case (cur_mode)
        swmf_pkg::MODE_DILATE:   level = hi;
        swmf_pkg::MODE_ERODE:    level = lo;
        swmf_pkg::MODE_GRADIENT: level = hi - lo;
        default:                 level = (hi + lo) / 2;
      endcase
      value = level[SAMPLE_BITS:0];
      if (seen >= half) begin
        step_outputs.push_back(filtered_t'{value: value, eow: is_last && half == 0});
        if (is_last) begin
          for (j = 0; j < half; j++)
            step_outputs.push_back(filtered_t'{value: value, eow: j + 1 == half});
        end
      end else begin
        // short stream: every output covers the whole waveform
        for (j = 0; j < span; j++)
          step_outputs.push_back(filtered_t'{value: value, eow: j + 1 == span});
      end
    end
    if (is_last) wave_count = '0;
  endfunction

  // wait until every owed output has come and the pipeline has settled
  task automatic wait_idle();
    while (pending_filtered.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [swmf_pkg::CFG_INDEX_BITS-1:0] index,
                           input logic [swmf_pkg::CFG_DATA_BITS-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = index;
    cfg_data  = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (index == swmf_pkg::CFG_WINDOW_LENGTH) cur_wl = value;
    else cur_mode = swmf_pkg::mode_t'(value[1:0]);
  endtask

  // offer one sample transaction, record what it should produce
  task automatic drive_sample(input logic signed [SAMPLE_BITS-1:0] x,
                              input logic is_last, input bit typed,
                              input filtered_t typed_res);
    while ($urandom_range(99) < send_gap_pct) begin
      sample_ch.valid = 1'b0;
      @(negedge clk);
    end
    sample_ch.valid  = 1'b1;
    sample_ch.sample = x;
    sample_ch.last   = is_last;
    do @(posedge clk); while (!sample_ch.ready);
    slide_window(x, is_last);
    if (typed) pending_filtered.push_back(typed_res);
    else foreach (step_outputs[i]) pending_filtered.push_back(step_outputs[i]);
    @(negedge clk);
    sample_ch.valid = 1'b0;
  endtask

  // new settings, weighted toward extremes and small windows
  task automatic shuffle_config(input bit both);
    logic [swmf_pkg::CFG_DATA_BITS-1:0] wl;
    case ($urandom_range(9))
      0:       wl = 7'd0;
      1:       wl = 7'd1;
      2:       wl = 7'd127;
      3:       wl = 7'd32;
      4:       wl = 7'd33;
      5:       wl = 7'd34;
      default: wl = 7'($urandom_range(2, 12));
    endcase
    if (both || $urandom_range(1) == 0) write_reg(swmf_pkg::CFG_WINDOW_LENGTH, wl);
    if (both || $urandom_range(1) == 0) write_reg(swmf_pkg::CFG_MODE, 7'($urandom_range(3)));
  endtask

  task automatic run_waveform(input int len);
    int i;
    logic signed [SAMPLE_BITS-1:0] x;
    for (i = 0; i < len; i++) begin
      // occasional settings change inside a waveform
      if (i > 0 && i < len - 1 && $urandom_range(19) == 0) begin
        wait_idle();
        shuffle_config(1'b0);
      end
      case ($urandom_range(7))
        0:       x = 16'sh7fff;
        1:       x = 16'sh8000;
        2:       x = -16'sd1;
        default: x = 16'($urandom);
      endcase
      drive_sample(x, i == len - 1, 1'b0, '0);
    end
  endtask

  task automatic run_phase(input int budget);
    int done, len;
    done = 0;
    while (done < budget) begin
      len = ($urandom_range(4) == 0) ? $urandom_range(25, 45) : $urandom_range(1, 20);
      wait_idle();
      shuffle_config(1'b1);
      run_waveform(len);
      done += len;
    end
  endtask

  // result side: random stalls while out of reset
  always @(negedge clk) begin
    if (rst) result_ch.ready = 1'b0;
    else result_ch.ready = ($urandom_range(99) >= recv_stall_pct);
  end

  // compare each result transaction with the oldest owed output
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_filtered.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: value %0d eow %0b",
                   result_ch.filtered_value, result_ch.end_of_waveform);
      end else begin
        head_filtered = pending_filtered.pop_front();
        if (result_ch.filtered_value !== head_filtered.value ||
            result_ch.end_of_waveform !== head_filtered.eow) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: expected value %0d eow %0b, got value %0d eow %0b",
                     head_filtered.value, head_filtered.eow,
                     result_ch.filtered_value, result_ch.end_of_waveform);
        end
      end
    end
  end

  initial begin
    #(TIMEOUT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int r;
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    sample_ch.valid  = 1'b0;
    sample_ch.sample = '0;
    sample_ch.last   = 1'b0;
    result_ch.ready  = 1'b0;
    fail_count       = 0;
    foreach (window_hist[i]) window_hist[i] = '0;
    wave_count = '0;
    cur_wl     = swmf_pkg::WL_RESET;
    cur_mode   = swmf_pkg::MODE_DILATE;
    send_gap_pct   = 7;
    recv_stall_pct = 80;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // directed table
    for (r = 0; r < DIRECTED_ROWS; r++) begin
      if (directed_rows[r].kind == ROW_WRITE) begin
        wait_idle();
        write_reg(directed_rows[r].reg_index, directed_rows[r].reg_value);
      end else begin
        drive_sample(directed_rows[r].x, directed_rows[r].is_last, directed_rows[r].typed,
                     filtered_t'{value: directed_rows[r].typed_value,
                                 eow: directed_rows[r].typed_eow});
      end
    end

    // random waveforms under three idling profiles
    run_phase(40);
    wait_idle();
    send_gap_pct   = 80;
    recv_stall_pct = 7;
    run_phase(40);
    wait_idle();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    run_phase(40);

    // one waveform long enough to saturate the sample count
    wait_idle();
    shuffle_config(1'b1);
    run_waveform(135);

    wait_idle();
    if (fail_count == 0 && pending_filtered.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[sliding_window_morph_filter_core.f]
+incdir+src
src/swmf_pkg.sv
src/swmf_if.sv
src/swmf_cell.sv
src/swmf_emit.sv
src/sliding_window_morph_filter_core.sv
src/swmf_checker.sv
sim/sliding_window_morph_filter_core_test.sv
